// ----- hdl/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list store package
// Request and response types, operation and error codes and the control word
// that steers one storage cell of the list.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned INDEX_W = 5;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [2:0] {
		OP_APPEND   = 3'd0,
		OP_INSERT   = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_READ     = 3'd3,
		OP_CONTAINS = 3'd4,
		OP_CLEAR    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef struct packed {
		logic [2:0]                op;
		logic [INDEX_W-1:0]        index;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  read_value;
		logic                      found;
		logic [1:0]                error;
		logic [COUNT_W-1:0]        count;
		logic                      is_empty;
	} rsp_t;

	// Per-cell update: load the request value, take the left neighbor's word
	// (insert shift) or take the right neighbor's word (remove shift).
	typedef struct packed {
		logic load;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

endpackage

// ----- hdl/indexed_list_store_unit.sv -----
// ----------------------------------------------------------------------------
// Indexed list store unit
// Bounded ordered list of signed 32-bit words held in a row of shift cells.
// ----------------------------------------------------------------------------
// The whole row of cells is updated in the cycle of the transfer and the
// response is held in an output register that appears the next cycle, so
// one request can be transferred per cycle as long as responses are
// taken. Throughput is set by the update of
// the cell row, where each cell chooses between holding, loading the request
// value and taking a neighbor's word. Inserts shift the cells at and above the
// position one place up, removes shift them one place down, and a membership
// test compares all stored words at once. Rejected requests change nothing.
// The count field of a response is the low five bits of the element count.
module indexed_list_store_unit #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ils_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ils_pkg::rsp_t rsp
);

	// Width of the element count, and a common width for position compares.
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (CNT_W > ils_pkg::INDEX_W) ? CNT_W : ils_pkg::INDEX_W;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_next;
	logic               rsp_valid_q;
	ils_pkg::rsp_t      rsp_q;
	ils_pkg::rsp_t      rsp_next;
	logic               accept;

	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   idx_ext;
	logic [CMP_W-1:0]   cnt_next_ext;

	logic signed [ils_pkg::DATA_W-1:0] cell_data [CAPACITY];
	logic                              cell_match [CAPACITY];
	ils_pkg::cell_ctl_t                cell_ctl [CAPACITY];

	logic               do_append;
	logic               do_insert;
	logic               do_remove;
	logic               do_read;
	logic               hit;
	logic signed [ils_pkg::DATA_W-1:0] rd_sel;
	ils_pkg::err_t      err;
	ils_pkg::op_t       op;

	// A new request is taken whenever the response register is free or is
	// being emptied in the same cycle.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign cnt_ext = CMP_W'(cnt_q);
	assign idx_ext = CMP_W'(req.index);
	assign op      = ils_pkg::op_t'(req.op);

	// Request decode and checks against the current count.
	always_comb begin
		do_append = 1'b0;
		do_insert = 1'b0;
		do_remove = 1'b0;
		do_read   = 1'b0;
		err       = ils_pkg::ERR_NONE;
		cnt_next  = cnt_q;
		unique case (op)
			ils_pkg::OP_APPEND: begin
				if (cnt_ext >= CAP_C) begin
					err = ils_pkg::ERR_FULL;
				end else begin
					do_append = 1'b1;
					cnt_next  = CNT_W'(cnt_q + 1'b1);
				end
			end
			ils_pkg::OP_INSERT: begin
				// The position check comes before the full check.
				if (idx_ext > cnt_ext) begin
					err = ils_pkg::ERR_RANGE;
				end else if (cnt_ext >= CAP_C) begin
					err = ils_pkg::ERR_FULL;
				end else begin
					do_insert = 1'b1;
					cnt_next  = CNT_W'(cnt_q + 1'b1);
				end
			end
			ils_pkg::OP_REMOVE: begin
				if (idx_ext >= cnt_ext) begin
					err = ils_pkg::ERR_RANGE;
				end else begin
					do_remove = 1'b1;
					cnt_next  = CNT_W'(cnt_q - 1'b1);
				end
			end
			ils_pkg::OP_READ: begin
				if (idx_ext >= cnt_ext) begin
					err = ils_pkg::ERR_RANGE;
				end else begin
					do_read = 1'b1;
				end
			end
			ils_pkg::OP_CONTAINS: begin
				cnt_next = cnt_q;
			end
			ils_pkg::OP_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
				// Unused operation codes report the current state only.
				cnt_next = cnt_q;
			end
		endcase
	end

	// Per-cell steering. Words above the count may shift freely since they
	// are never observed until rewritten.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_ctl[i].load       = accept &&
				((do_append && (CMP_W'(i) == cnt_ext)) ||
				 (do_insert && (CMP_W'(i) == idx_ext)));
			cell_ctl[i].take_left  = accept && do_insert && (CMP_W'(i) > idx_ext);
			cell_ctl[i].take_right = accept && do_remove && (CMP_W'(i) >= idx_ext);
		end
	end

	// The cell row. The left input of the first cell and the right input of
	// the last cell are never selected for a stored position.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [ils_pkg::DATA_W-1:0] left_w;
		logic signed [ils_pkg::DATA_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = req.value;
		end else begin : g_inner_l
			assign left_w = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[g];
		end else begin : g_inner_r
			assign right_w = cell_data[g+1];
		end

		ils_cell u_cell (
			.clk   (clk),
			.ctl   (cell_ctl[g]),
			.value (req.value),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[g]),
			.match (cell_match[g])
		);
	end

	// Read selection and membership test over the stored words only.
	always_comb begin
		rd_sel = '0;
		hit    = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMP_W'(i) == idx_ext) begin
				rd_sel = cell_data[i];
			end
			if (cell_match[i] && (CMP_W'(i) < cnt_ext)) begin
				hit = 1'b1;
			end
		end
	end

	assign cnt_next_ext = CMP_W'(cnt_next);

	always_comb begin
		rsp_next.read_value = do_read ? rd_sel : '0;
		rsp_next.found      = (op == ils_pkg::OP_CONTAINS) && hit;
		rsp_next.error      = err;
		rsp_next.count      = cnt_next_ext[ils_pkg::COUNT_W-1:0];
		rsp_next.is_empty   = (cnt_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_next;
			end
			if (req_ready) begin
				rsp_valid_q <= req_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/ils_cell.sv -----
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one list word, shifts toward either neighbor or loads a new word, and
// compares its word with the request value.
// ----------------------------------------------------------------------------
module ils_cell (
	input  logic                              clk,
	input  ils_pkg::cell_ctl_t                ctl,
	input  logic signed [ils_pkg::DATA_W-1:0] value,
	input  logic signed [ils_pkg::DATA_W-1:0] left,
	input  logic signed [ils_pkg::DATA_W-1:0] right,
	output logic signed [ils_pkg::DATA_W-1:0] data,
	output logic                              match
);

	logic signed [ils_pkg::DATA_W-1:0] data_q;

	// The three controls never rise together; with none of them the cell holds.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= value;
		end else if (ctl.take_left) begin
			data_q <= left;
		end else if (ctl.take_right) begin
			data_q <= right;
		end
	end

	assign data  = data_q;
	assign match = (data_q == value);

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store unit testbench
// Drives list requests through the request channel and checks every
// response against a cycle-free list predictor kept in a small scoreboard.
// A short directed sequence comes first. Random request bursts follow, some
// growing the list until it is full and some shrinking it until it is
// empty. The sender and the receiver idle at different rates from phase to
// phase.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned LIST_CAP     = 16;
	localparam int unsigned RANDOM_ITEMS = 1740;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned DATA_W       = ils_pkg::DATA_W;
	localparam int unsigned INDEX_W      = ils_pkg::INDEX_W;
	localparam int unsigned COUNT_W      = ils_pkg::COUNT_W;

	// Op codes 6 and 7 are unused. The block must answer them as no-ops.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// The scoreboard holds its own copy of the list. Each accepted request
	// updates that copy and queues the response the block should send.
	class list_scoreboard;
		logic signed [DATA_W-1:0] slots [LIST_CAP];
		int unsigned              fill;
		ils_pkg::rsp_t            awaited_rsp [$];
		int unsigned              mismatches;
		int unsigned              n_requests;
		int unsigned              n_checked;
		int unsigned              n_full;
		int unsigned              n_range;
		int unsigned              n_found;

		function new();
			fill = 0;
			mismatches = 0;
			n_requests = 0;
			n_checked = 0;
			n_full = 0;
			n_range = 0;
			n_found = 0;
		endfunction

		function int unsigned pending();
			return awaited_rsp.size();
		endfunction

		function logic signed [DATA_W-1:0] stored_at(int unsigned pos);
			return slots[pos];
		endfunction

		// Applies one request to the list copy and returns its response.
		function ils_pkg::rsp_t apply_request(ils_pkg::req_t r);
			ils_pkg::rsp_t o;
			o = '0;
			case (r.op)
				ils_pkg::OP_APPEND: begin
					if (fill >= LIST_CAP) begin
						o.error = ils_pkg::ERR_FULL;
					end else begin
						slots[fill] = r.value;
						fill++;
					end
				end
				ils_pkg::OP_INSERT: begin
					// The position check wins over the full check.
					if (r.index > fill) begin
						o.error = ils_pkg::ERR_RANGE;
					end else if (fill >= LIST_CAP) begin
						o.error = ils_pkg::ERR_FULL;
					end else begin
						for (int i = fill; i > r.index; i--)
							slots[i] = slots[i-1];
						slots[r.index] = r.value;
						fill++;
					end
				end
				ils_pkg::OP_REMOVE: begin
					if (r.index >= fill) begin
						o.error = ils_pkg::ERR_RANGE;
					end else begin
						for (int i = r.index; i + 1 < fill; i++)
							slots[i] = slots[i+1];
						fill--;
					end
				end
				ils_pkg::OP_READ: begin
					if (r.index >= fill)
						o.error = ils_pkg::ERR_RANGE;
					else
						o.read_value = slots[r.index];
				end
				ils_pkg::OP_CONTAINS: begin
					// Stale words past the count never match.
					for (int i = 0; i < fill; i++)
						if (slots[i] == r.value)
							o.found = 1'b1;
				end
				ils_pkg::OP_CLEAR: begin
					fill = 0;
				end
				default: begin
				end
			endcase
			o.count    = COUNT_W'(fill);
			o.is_empty = (fill == 0);
			return o;
		endfunction

		function void note_request(ils_pkg::req_t r);
			ils_pkg::rsp_t o;
			o = apply_request(r);
			n_requests++;
			if (o.error == ils_pkg::ERR_FULL)
				n_full++;
			if (o.error == ils_pkg::ERR_RANGE)
				n_range++;
			if (o.found)
				n_found++;
			awaited_rsp.push_back(o);
		endfunction

		function bit field_ok(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
			if (act !== exp) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_response(ils_pkg::rsp_t got);
			ils_pkg::rsp_t exp;
			bit            ok;
			if (awaited_rsp.size() == 0) begin
				$display("%0t: unexpected response %0h with nothing awaited", $time, got);
				mismatches++;
				return;
			end
			exp = awaited_rsp.pop_front();
			n_checked++;
			ok = field_ok("read_value", exp.read_value, got.read_value);
			ok = field_ok("found", exp.found, got.found) && ok;
			ok = field_ok("error", exp.error, got.error) && ok;
			ok = field_ok("count", exp.count, got.count) && ok;
			ok = field_ok("is_empty", exp.is_empty, got.is_empty) && ok;
			if (!ok)
				mismatches++;
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	ils_pkg::req_t  req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	ils_pkg::rsp_t  rsp;

	// Idle rates in percent, changed between phases.
	int unsigned sender_idle_pct = 0;
	int unsigned rcv_stall_pct = 0;

	// Flipping this asks the response sink for one long hold-off.
	bit hold_toggle = 1'b0;

	list_scoreboard sb = new();

	always #10 clk = ~clk;

	indexed_list_store_unit #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Response sink. Every transfer on the response channel is checked at the
	// edge where it happens. The ready for the next cycle is then chosen by
	// the stall rate, or held low for a counted stretch when a hold-off has
	// been asked for.
	initial begin : response_sink
		bit          hold_seen;
		int unsigned hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready)
				sb.check_response(rsp);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// Offers one request and returns at the edge of its transfer. A random
	// gap may come first, during which valid is low. Once valid is high it
	// stays high with the same payload until the transfer.
	task automatic send_req(input ils_pkg::req_t item);
		if ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		req       <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(item);
	endtask

	// Stops offering until every awaited response has arrived.
	task automatic wait_for_responses();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic ils_pkg::req_t make_req(logic [2:0] op, logic [INDEX_W-1:0] idx,
			logic signed [DATA_W-1:0] val);
		ils_pkg::req_t r;
		r.op    = op;
		r.index = idx;
		r.value = val;
		return r;
	endfunction

	// Values lean toward small numbers and the extremes now and then, so
	// that duplicates and boundary words show up in the list.
	function automatic logic signed [DATA_W-1:0] random_word();
		case ($urandom_range(7))
			0: return DATA_W'($signed($urandom_range(8)) - 4);
			1: begin
				case ($urandom_range(3))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Builds one random request. grow_pct sets the share of appends and
	// inserts, which steers the list toward full or toward empty. Positions
	// mostly fall between zero and one past the list length, and now and then take
	// any value the field allows.
	function automatic ils_pkg::req_t random_request(int unsigned grow_pct);
		ils_pkg::req_t r;
		int unsigned   n;
		int unsigned   roll;
		n = sb.fill;
		roll = $urandom_range(99);
		r.value = random_word();
		if (roll < 3) begin
			r.op = ils_pkg::OP_CLEAR;
		end else if (roll < 5) begin
			r.op = ($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
		end else if ($urandom_range(99) < grow_pct) begin
			r.op = ($urandom_range(1) == 0) ? ils_pkg::OP_APPEND : ils_pkg::OP_INSERT;
		end else begin
			case ($urandom_range(2))
				0: r.op = ils_pkg::OP_REMOVE;
				1: r.op = ils_pkg::OP_READ;
				default: r.op = ils_pkg::OP_CONTAINS;
			endcase
		end
		if ($urandom_range(9) == 0)
			r.index = INDEX_W'($urandom);
		else
			r.index = INDEX_W'($urandom_range(n + 1));
		// Half of the membership tests look for a word that is stored.
		if (r.op == ils_pkg::OP_CONTAINS && n > 0 && $urandom_range(1) == 0)
			r.value = sb.stored_at($urandom_range(n - 1));
		return r;
	endfunction

	// Hard limit on the run. The slowest correct run is far shorter.
	initial begin : watchdog
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase_idle [4];
		int unsigned phase_stall [4];
		int unsigned grow_pct;
		int unsigned per_phase;
		per_phase = RANDOM_ITEMS / 4;
		// Phase order: no idling, sender idle, receiver stalling, both.
		phase_idle  = '{0, 59, 0, 36};
		phase_stall = '{0, 0, 59, 36};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The list starts empty, so reads and removes must
		// report a bad position. The extremes of the value field go in, an
		// insert at the count acts as an append, an insert past the end is
		// refused, and after a clear the stale words must not be found.
		send_req(make_req(ils_pkg::OP_READ, 5'd0, 32'sd0));
		send_req(make_req(ils_pkg::OP_REMOVE, 5'd0, 32'sd0));
		send_req(make_req(OP_SPARE_6, 5'd31, '1));
		send_req(make_req(ils_pkg::OP_APPEND, 5'd0, 32'sh7fff_ffff));
		send_req(make_req(ils_pkg::OP_APPEND, 5'd31, 32'sh8000_0000));
		send_req(make_req(ils_pkg::OP_INSERT, 5'd0, 32'sd0));
		send_req(make_req(ils_pkg::OP_INSERT, 5'd3, -32'sd1));
		send_req(make_req(ils_pkg::OP_INSERT, 5'd31, 32'sd7));
		send_req(make_req(ils_pkg::OP_READ, 5'd1, 32'sd0));
		send_req(make_req(ils_pkg::OP_READ, 5'd31, 32'sd0));
		send_req(make_req(ils_pkg::OP_CONTAINS, 5'd0, 32'sh8000_0000));
		send_req(make_req(ils_pkg::OP_CONTAINS, 5'd0, 32'sd12345));
		send_req(make_req(ils_pkg::OP_REMOVE, 5'd1, 32'sd0));
		send_req(make_req(OP_SPARE_7, 5'd16, 32'sh5555_aaaa));
		send_req(make_req(ils_pkg::OP_READ, 5'd3, 32'sd0));
		send_req(make_req(ils_pkg::OP_CLEAR, 5'd0, 32'sd0));
		send_req(make_req(ils_pkg::OP_CONTAINS, 5'd0, -32'sd1));
		send_req(make_req(ils_pkg::OP_READ, 5'd0, 32'sd0));
		wait_for_responses();

		// Random part, in four phases with different idle rates. Bursts of
		// forty requests switch between growing, balanced and shrinking
		// traffic, so the list runs through full and empty many times.
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct <= phase_idle[p];
			rcv_stall_pct   <= phase_stall[p];
			grow_pct = 80;
			for (int k = 0; k < per_phase; k++) begin
				if (k % 40 == 0) begin
					case ($urandom_range(2))
						0: grow_pct = 80;
						1: grow_pct = 50;
						default: grow_pct = 20;
					endcase
				end
				// The receiver holds off for a long stretch while requests
				// keep coming, so the block backs up and stalls its input.
				if (k == 100 && (p == 0 || p == 3))
					hold_toggle <= ~hold_toggle;
				if ($urandom_range(149) == 0)
					wait_for_responses();
				send_req(random_request(grow_pct));
			end
			wait_for_responses();
		end

		// Keep running for any stray response from the response register.
		repeat (8) @(posedge clk);

		$display("Ran %0d list requests and checked %0d responses.", sb.n_requests,
			sb.n_checked);
		$display("Saw %0d full refusals, %0d bad positions and %0d membership hits.",
			sb.n_full, sb.n_range, sb.n_found);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ils_pkg.sv
hdl/ils_cell.sv
hdl/indexed_list_store_unit.sv
sim/tb_top.sv
